>>> design/mfsk_tone_modulator_defines.svh
// Assertion macros shared by the MFSK tone modulator RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MFSK_TONE_MODULATOR_DEFINES_SVH
`define MFSK_TONE_MODULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mfsk_pkg.sv
// Shared constants, types and the sine table generator for the MFSK modulator.
// No dependencies; imported by every module of the block.
package mfsk_pkg;

    // Sizing
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int LENGTH_BITS    = 24;
    localparam int SAMPLE_BITS    = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int FADE_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HELLO_STEP  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TERM_STEP   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_RECIP  = 3'd6;

    localparam logic [FADE_W-1:0] FADE_LENGTH_RESET = 16'd240;
    localparam logic [FADE_W-1:0] FADE_RECIP_RESET  = 16'd273;

    // Input word codes
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_DATA    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SILENCE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HELLO   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TERM    = 3'd4;
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam int BYTE_W = 8;
    localparam int SEG_W  = 24;
    localparam int SYM_W  = BYTE_W + 1;
    localparam logic [SYM_W-1:0] REPEAT_SYMBOL = 9'd256;

    // Sine table: quarter wave, split into banks of at most 256 words
    localparam int SINE_W         = 15;
    localparam int ROM_SIZE       = 1 << SINE_ADDR_BITS;
    localparam int BANK_ADDR_BITS = (SINE_ADDR_BITS > 8) ? 8 : SINE_ADDR_BITS;
    localparam int BANK_BITS      = SINE_ADDR_BITS - BANK_ADDR_BITS;
    localparam int BANKS          = 1 << BANK_BITS;
    localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sample scaling: q = |s| * r * 9 * FULL_SCALE / (65536 * 327670)
    localparam int RAMP_W    = 17;
    localparam logic [RAMP_W-1:0] RAMP_ONE = 17'h10000;
    localparam int FULL_SCALE = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int GAIN_W    = SAMPLE_BITS + 3;
    localparam logic [GAIN_W-1:0] GAIN_K = GAIN_W'(9 * FULL_SCALE);
    localparam int MAG_W     = SINE_W + RAMP_W;
    localparam int SCALED_W  = MAG_W + GAIN_W - 16;
    localparam int DIV_W     = 19;
    localparam logic [DIV_W-1:0] DIVISOR = 19'd327670;
    localparam int RECIP_W   = SCALED_W - 18;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SCALED_W) / 64'd327670);
    localparam int Q_W       = SAMPLE_BITS;

    // Command queue
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_ADDR_W = 2;
    localparam int FIFO_LVL_W  = 3;

    typedef struct packed {
        logic [STEP_W-1:0] base_step;
        logic [STEP_W-1:0] bin_step;
        logic [STEP_W-1:0] hello_step;
        logic [STEP_W-1:0] header_step;
        logic [STEP_W-1:0] term_step;
        logic [FADE_W-1:0] fade_length;
        logic [FADE_W-1:0] fade_recip;
    } cfg_t;

    typedef struct packed {
        logic                   is_start;
        logic                   tone_en;
        logic [PHASE_BITS-1:0]  inc;
        logic [LENGTH_BITS-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Q15 quarter-wave entry k, Taylor series in Q30, evaluated at elaboration
    function automatic logic [SINE_W-1:0] sine_value(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      v;
        x    = (64'(2 * k + 1) * HALF_PI_Q30) / 64'(2 * ROM_SIZE);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum + 16384) >>> 15;
        if (v > 32767)
            v = 32767;
        return SINE_W'(v);
    endfunction

endpackage

>>> design/mfsk_cmd_fifo.sv
// Four-entry command queue between the front end and the sample engine.
// Depends on mfsk_pkg (cmd_t, fifo_stat_t, queue sizing).
module mfsk_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfsk_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output mfsk_pkg::cmd_t    pop_cmd,
    output mfsk_pkg::fifo_stat_t stat
);
    import mfsk_pkg::*;

    cmd_t                   mem_reg [FIFO_DEPTH];
    logic [FIFO_ADDR_W-1:0] wr_ptr_reg;
    logic [FIFO_ADDR_W-1:0] rd_ptr_reg;
    logic [FIFO_LVL_W-1:0]  count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign stat.full  = (count_reg == FIFO_LVL_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> design/mfsk_front.sv
// Front end: accepts input words, applies the repeat-symbol rule and
// works out each segment's phase step. Depends on mfsk_pkg.
module mfsk_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mfsk_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    input  logic [mfsk_pkg::KIND_W-1:0]   in_kind,
    input  logic [mfsk_pkg::BYTE_W-1:0]   in_byte,
    input  logic [mfsk_pkg::SEG_W-1:0]    in_len,
    output logic                          push,
    output mfsk_pkg::cmd_t                push_cmd,
    input  mfsk_pkg::fifo_stat_t          fifo_stat
);
    import mfsk_pkg::*;

    // Repeat history
    logic [BYTE_W-1:0] prev_byte_reg;
    logic              prev_valid_reg;
    logic              last_esc_reg;

    // Pending command slot
    logic                   pend_valid_reg;
    logic                   pend_start_reg;
    logic                   pend_tone_reg;
    logic [PHASE_BITS-1:0]  pend_addend_reg;
    logic [PHASE_BITS-1:0]  pend_prod_reg;
    logic [LENGTH_BITS-1:0] pend_len_reg;

    logic                    accept;
    logic                    repeat_hit;
    logic [SYM_W-1:0]        sym;
    logic [SYM_W-1:0]        mul_sym;
    logic [PHASE_BITS-1:0]   addend;
    logic                    tone_en;
    logic [STEP_W+SYM_W-1:0] prod_full;

    assign in_ready   = !pend_valid_reg;
    assign accept     = in_valid && in_ready;
    assign repeat_hit = prev_valid_reg && (in_byte == prev_byte_reg) && !last_esc_reg;
    assign sym        = repeat_hit ? REPEAT_SYMBOL : {1'b0, in_byte};

    // Classify the segment kind
    always_comb
    begin
        addend  = '0;
        mul_sym = '0;
        tone_en = 1'b1;
        unique case (in_kind)
            KIND_DATA:
            begin
                addend  = PHASE_BITS'(cfg.base_step);
                mul_sym = sym;
            end
            KIND_HELLO:  addend = PHASE_BITS'(cfg.hello_step);
            KIND_HEADER: addend = PHASE_BITS'(cfg.header_step);
            KIND_TERM:   addend = PHASE_BITS'(cfg.term_step);
            default:     tone_en = 1'b0;   // silence and unused kinds
        endcase
    end

    assign prod_full = cfg.bin_step * mul_sym;

    // From the pending slot: finish the step and hand the word to the queue
    assign push              = pend_valid_reg && !fifo_stat.full;
    assign push_cmd.is_start = pend_start_reg;
    assign push_cmd.tone_en  = pend_tone_reg;
    assign push_cmd.inc      = pend_addend_reg + pend_prod_reg;
    assign push_cmd.len      = pend_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            last_esc_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                pend_valid_reg <= 1'b0;
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
                if (in_func == FUNC_START)
                begin
                    if (in_kind == KIND_DATA)
                    begin
                        prev_byte_reg  <= in_byte;
                        prev_valid_reg <= 1'b1;
                        last_esc_reg   <= repeat_hit;
                    end
                    else if (in_kind == KIND_HELLO)
                    begin
                        prev_valid_reg <= 1'b0;
                        last_esc_reg   <= 1'b0;
                    end
                end
            end
        end
    end

    // Pending payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_start_reg  <= (in_func == FUNC_START);
            pend_tone_reg   <= tone_en;
            pend_addend_reg <= addend;
            pend_prod_reg   <= PHASE_BITS'(prod_full);
            pend_len_reg    <= LENGTH_BITS'(in_len);
        end
    end

endmodule

>>> design/mfsk_back.sv
// Sample engine: runs segment state, the sine table, the fade ramp and the
// gain scaling, one tick at a time. Depends on mfsk_pkg.
module mfsk_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mfsk_pkg::cfg_t                 cfg,
    output logic                           pop,
    input  mfsk_pkg::cmd_t                 pop_cmd,
    input  mfsk_pkg::fifo_stat_t           fifo_stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mfsk_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                           out_last,
    output logic                           out_idle
);
    import mfsk_pkg::*;

    localparam int RSUM_W = LENGTH_BITS + FADE_W + 1;

    typedef enum logic [2:0] {
        B_POP,
        B_RAMP,
        B_MAG,
        B_SCALE,
        B_RECIP,
        B_CHECK,
        B_OUT
    } back_state_t;

    back_state_t state_reg;

    // Segment state
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  inc_reg;
    logic                   tone_reg;
    logic [LENGTH_BITS-1:0] idx_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic                   active_reg;

    // Per-tick pipeline
    logic [SINE_W-1:0]      rom_q_reg;
    logic                   neg_reg;
    logic [LENGTH_BITS-1:0] opnd_reg;
    logic                   full_reg;
    logic                   last_reg;
    logic                   tone_p_reg;
    logic                   idle_p_reg;
    logic [RAMP_W-1:0]      ramp_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [SCALED_W-1:0]    scaled_reg;
    logic [Q_W-1:0]         qe_reg;
    logic [Q_W+DIV_W-1:0]   qd_reg;

    // Result register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_last_reg;
    logic                   out_idle_reg;

    // Sine table address: top phase bits, mirrored in odd quadrants
    logic [SINE_ADDR_BITS+1:0]   phase_top;
    logic [SINE_ADDR_BITS-1:0]   rom_addr;
    logic [SINE_W-1:0]           bank_w  [BANKS][BANK_DEPTH];
    logic [SINE_W-1:0]           bank_rd [BANKS];
    logic [SINE_W-1:0]           rom_word;

    assign phase_top = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
    assign rom_addr  = phase_top[SINE_ADDR_BITS] ? ~phase_top[SINE_ADDR_BITS-1:0]
                                                 : phase_top[SINE_ADDR_BITS-1:0];

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        for (genvar k = 0; k < BANK_DEPTH; k++)
        begin : g_word
            localparam logic [SINE_W-1:0] WORD = sine_value(b * BANK_DEPTH + k);
            assign bank_w[b][k] = WORD;
        end
        assign bank_rd[b] = bank_w[b][rom_addr[BANK_ADDR_BITS-1:0]];
    end

    if (BANK_BITS == 0)
    begin : g_one_bank
        assign rom_word = bank_rd[0];
    end
    else
    begin : g_banks
        assign rom_word = bank_rd[rom_addr[SINE_ADDR_BITS-1:BANK_ADDR_BITS]];
    end

    // Fade ramp region for the current index
    logic [RSUM_W-1:0]      idx_ext;
    logic [RSUM_W-1:0]      fl_ext;
    logic [RSUM_W-1:0]      len_ext;
    logic                   fade_in;
    logic                   fade_out;
    logic                   ramp_full;
    logic [LENGTH_BITS-1:0] ramp_opnd;

    assign idx_ext   = RSUM_W'(idx_reg);
    assign fl_ext    = RSUM_W'(cfg.fade_length);
    assign len_ext   = RSUM_W'(len_reg);
    assign fade_in   = idx_ext < fl_ext;
    assign fade_out  = (idx_ext + fl_ext) >= len_ext;
    assign ramp_full = (cfg.fade_length == '0) || (!fade_in && !fade_out);
    assign ramp_opnd = fade_in ? idx_reg : (len_reg - 1'b1 - idx_reg);

    // Segment advance
    logic [LENGTH_BITS-1:0] idx_inc;
    assign idx_inc = idx_reg + 1'b1;

    // Arithmetic between stages
    logic [LENGTH_BITS+FADE_W-1:0] ramp_prod;
    logic [RAMP_W-1:0]             ramp_sat;
    logic [MAG_W+GAIN_W-1:0]       gain_prod;
    logic [SCALED_W+RECIP_W-1:0]   recip_prod;
    logic [SCALED_W+RECIP_W-1:0]   recip_shift;
    logic [SCALED_W-1:0]           rem;
    logic                          corr;
    logic [Q_W-1:0]                quot;
    logic [SAMPLE_BITS-1:0]        pcm_word;

    assign ramp_prod   = opnd_reg * cfg.fade_recip;
    assign ramp_sat    = (full_reg || (ramp_prod > (LENGTH_BITS+FADE_W)'(RAMP_ONE)))
                         ? RAMP_ONE : RAMP_W'(ramp_prod);
    assign gain_prod   = mag_reg * GAIN_K;
    assign recip_prod  = scaled_reg * RECIP;
    assign recip_shift = recip_prod >> SCALED_W;
    assign rem         = scaled_reg - SCALED_W'(qd_reg);
    assign corr        = rem >= SCALED_W'(DIVISOR);
    assign quot        = qe_reg + Q_W'(corr);
    assign pcm_word    = (idle_p_reg || !tone_p_reg) ? '0
                         : (neg_reg ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot));

    assign pop        = (state_reg == B_POP) && !fifo_stat.empty;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
    assign out_idle   = out_idle_reg;

    // Sequencer, segment state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_POP;
            phase_reg     <= '0;
            inc_reg       <= '0;
            tone_reg      <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // B_OUT reloads the result register itself
            if (out_valid_reg && out_ready && (state_reg != B_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_POP:
                begin
                    if (pop)
                    begin
                        if (pop_cmd.is_start)
                        begin
                            inc_reg    <= pop_cmd.inc;
                            tone_reg   <= pop_cmd.tone_en;
                            len_reg    <= pop_cmd.len;
                            active_reg <= (pop_cmd.len != '0);
                            phase_reg  <= '0;
                            idx_reg    <= '0;
                        end
                        else if (!active_reg)
                        begin
                            idle_p_reg <= 1'b1;
                            state_reg  <= B_OUT;
                        end
                        else
                        begin
                            idle_p_reg <= 1'b0;
                            tone_p_reg <= tone_reg;
                            rom_q_reg  <= rom_word;
                            neg_reg    <= phase_top[SINE_ADDR_BITS+1];
                            opnd_reg   <= ramp_opnd;
                            full_reg   <= ramp_full;
                            last_reg   <= (idx_inc == len_reg);
                            phase_reg  <= phase_reg + inc_reg;
                            if (idx_inc >= len_reg)
                            begin
                                active_reg <= 1'b0;
                                idx_reg    <= '0;
                            end
                            else
                                idx_reg <= idx_inc;
                            state_reg <= B_RAMP;
                        end
                    end
                end
                B_RAMP:
                begin
                    ramp_reg  <= ramp_sat;
                    state_reg <= B_MAG;
                end
                B_MAG:
                begin
                    mag_reg   <= rom_q_reg * ramp_reg;
                    state_reg <= B_SCALE;
                end
                B_SCALE:
                begin
                    scaled_reg <= gain_prod[MAG_W+GAIN_W-1:16];
                    state_reg  <= B_RECIP;
                end
                B_RECIP:
                begin
                    qe_reg    <= Q_W'(recip_shift);
                    state_reg <= B_CHECK;
                end
                B_CHECK:
                begin
                    qd_reg    <= qe_reg * DIVISOR;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= pcm_word;
                        out_last_reg   <= !idle_p_reg && last_reg;
                        out_idle_reg   <= idle_p_reg;
                        state_reg      <= B_POP;
                    end
                end
                default: state_reg <= B_POP;
            endcase
        end
    end

endmodule

>>> design/mfsk_tone_modulator.sv
// MFSK tone modulator. Input words are either a segment start (tuser func
// set: kind, data byte and segment length) or a sample tick; each tick
// returns one signed PCM sample, with tlast on the final sample of a segment
// and tuser set when no segment is running (sample zero). A data byte equal
// to the previous one, unless that one was already replaced, is sent as the
// repeat symbol; a hello start clears that history. The front end holds one
// word in its pending slot and takes no new word until that word is in the
// four-word command queue; the sample engine behind it finishes each tick
// (on a running segment: table read, ramp multiply, gain multiply, reciprocal
// divide by a constant and a correction step) before it pops the next word.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce this. There is no read-back.
`include "mfsk_tone_modulator_defines.svh"

module mfsk_tone_modulator (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [mfsk_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mfsk_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // data_byte[7:0], segment_samples[31:8]
    input  logic [3:0]                         s_axis_tuser,  // func[0], kind[3:1]
    // Sample stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mfsk_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,  // sample
    output logic                               m_axis_tlast,  // last_sample
    output logic                               m_axis_tuser   // idle
);
    import mfsk_pkg::*;

    cfg_t       cfg_reg;
    logic       fifo_push;
    cmd_t       fifo_push_cmd;
    logic       fifo_pop;
    cmd_t       fifo_pop_cmd;
    fifo_stat_t fifo_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_step   <= '0;
            cfg_reg.bin_step    <= '0;
            cfg_reg.hello_step  <= '0;
            cfg_reg.header_step <= '0;
            cfg_reg.term_step   <= '0;
            cfg_reg.fade_length <= FADE_LENGTH_RESET;
            cfg_reg.fade_recip  <= FADE_RECIP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_STEP:   cfg_reg.base_step   <= cfg_data;
                REG_BIN_STEP:    cfg_reg.bin_step    <= cfg_data;
                REG_HELLO_STEP:  cfg_reg.hello_step  <= cfg_data;
                REG_HEADER_STEP: cfg_reg.header_step <= cfg_data;
                REG_TERM_STEP:   cfg_reg.term_step   <= cfg_data;
                REG_FADE_LENGTH: cfg_reg.fade_length <= cfg_data[FADE_W-1:0];
                REG_FADE_RECIP:  cfg_reg.fade_recip  <= cfg_data[FADE_W-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    mfsk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser[0]),
        .in_kind   (s_axis_tuser[3:1]),
        .in_byte   (s_axis_tdata[7:0]),
        .in_len    (s_axis_tdata[31:8]),
        .push      (fifo_push),
        .push_cmd  (fifo_push_cmd),
        .fifo_stat (fifo_stat)
    );

    mfsk_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_cmd (fifo_push_cmd),
        .pop      (fifo_pop),
        .pop_cmd  (fifo_pop_cmd),
        .stat     (fifo_stat)
    );

    mfsk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop        (fifo_pop),
        .pop_cmd    (fifo_pop_cmd),
        .fifo_stat  (fifo_stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_idle   (m_axis_tuser)
    );

    // Checks
    `MFSK_ASSERT_NOW(a_idle_word_silent, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == '0) && !m_axis_tlast, "idle word carries a sample or tlast")
    `MFSK_ASSERT_NEXT(a_front_one_word, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front took a word while its slot was busy")
    `MFSK_ASSERT_NOW(a_no_push_when_full, fifo_stat.full, !fifo_push, "command pushed into a full queue")

endmodule
